/* rtl/afc8_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the addressed frame checker.
package afc8_pkg;

    localparam int DEFAULT_MAX_PACKET_BYTES = 64;
    localparam int MIN_PACKET_BYTES         = 4;
    localparam int COUNT_W                  = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [7:0] CRC_INIT          = 8'hFF;
    localparam logic [7:0] CRC_POLY          = 8'h31;
    localparam logic [7:0] LED_COMMAND       = 8'h1A;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_OVERLENGTH = 3'd1,
        STATUS_SHORT      = 3'd2,
        STATUS_ADDRESS    = 3'd3,
        STATUS_CRC        = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } afc8_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic       led_lit;
    } afc8_result_t;

    // CRC-8, MSB first, no reflection, no final XOR
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/addressed_frame_crc8_checker.sv */
// Top level of the addressed frame checker: input register, evaluation and result register.
//
// Takes one packet byte per cycle with a last-of-packet mark and, for each marked
// byte, returns one result: status (ok, overlength, short, wrong address, CRC
// mismatch, tested in that order), the command byte (third byte, zero unless ok)
// and a sticky LED flag set by an ok packet with command 0x1A. The marked byte is
// compared with the CRC-8 (poly 0x31, init 0xFF, MSB first) of all bytes before
// it. Throughput is one byte per cycle while the input does not stall, set by the
// byte-wide CRC XOR network; the input register takes the last byte and the result
// register takes its verdict from it when the result register is free. The input
// stalls only while a last byte waits behind a stalled result. device_address is
// written through cfg with cfg_ready always high.
module addressed_frame_crc8_checker
    import afc8_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  afc8_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output afc8_result_t result,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    logic         s1_valid_reg, s1_valid_next;
    afc8_item_t   s1_reg;
    logic         out_valid_reg, out_valid_next;
    afc8_result_t out_reg;
    logic [7:0]   address_reg;

    logic         out_free;
    logic         s1_go;
    afc8_result_t eval_result;

    assign cfg_ready = 1'b1;

    // a non-last byte never needs the result register
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_go      = s1_valid_reg && (!s1_reg.last_byte || out_free);
    assign item_stall = s1_valid_reg && !s1_go;

    afc8_frame_eval #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_go),
        .item           (s1_reg),
        .device_address (address_reg),
        .result         (eval_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_valid && !item_stall)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go && s1_reg.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            address_reg   <= 8'h00;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                address_reg <= cfg_data;
            end
        end
    end

    // payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_reg <= item;
        end
        if (s1_go && s1_reg.last_byte)
        begin
            out_reg <= eval_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_command_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STATUS_OK |-> result.command == 8'h00)
        else $error("command nonzero on failed packet");

    a_led_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_OK && result.command == LED_COMMAND
        |-> result.led_lit)
        else $error("LED flag not set by LED command");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && s1_reg.last_byte && out_valid_reg && result_stall)
        else $error("input stalled without a blocked result");

endmodule

/* rtl/afc8_frame_eval.sv */
// Per-packet state (CRC, count, kept bytes, LED latch) and the end-of-packet verdict.
module afc8_frame_eval
    import afc8_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEFAULT_MAX_PACKET_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  afc8_item_t   item,
    input  logic [7:0]   device_address,
    output afc8_result_t result
);

    logic [7:0]         crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         command_reg, command_next;
    logic               led_reg, led_next;

    logic [7:0] length;
    status_t    status;

    assign length = {1'b0, count_reg} + 8'd1;

    always_comb
    begin
        priority if (count_reg == COUNT_MAX || length > 8'(MAX_PACKET_BYTES))
        begin
            status = STATUS_OVERLENGTH;
        end
        else if (length < 8'(MIN_PACKET_BYTES))
        begin
            status = STATUS_SHORT;
        end
        else if (first_reg != device_address)
        begin
            status = STATUS_ADDRESS;
        end
        else if (crc_reg != item.rx_byte)
        begin
            status = STATUS_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        command_next = command_reg;
        led_next     = led_reg;
        if (step)
        begin
            if (item.last_byte)
            begin
                // close the packet and start fresh
                crc_next     = CRC_INIT;
                count_next   = '0;
                first_next   = '0;
                command_next = '0;
                if (status == STATUS_OK && command_reg == LED_COMMAND)
                begin
                    led_next = 1'b1;
                end
            end
            else
            begin
                if (count_reg == COUNT_W'(0))
                begin
                    first_next = item.rx_byte;
                end
                else if (count_reg == COUNT_W'(2))
                begin
                    command_next = item.rx_byte;
                end
                crc_next = crc8_byte(crc_reg, item.rx_byte);
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        result.status  = status;
        result.command = (status == STATUS_OK) ? command_reg : 8'h00;
        result.led_lit = led_reg | (status == STATUS_OK && command_reg == LED_COMMAND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            count_reg   <= '0;
            first_reg   <= '0;
            command_reg <= '0;
            led_reg     <= 1'b0;
        end
        else
        begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            command_reg <= command_next;
            led_reg     <= led_next;
        end
    end

    a_led_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(led_reg))
        else $error("LED latch cleared outside reset");

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> count_reg == '0 && crc_reg == CRC_INIT)
        else $error("packet state not cleared after last byte");

    a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last_byte && count_reg == '0 |=> first_reg == $past(item.rx_byte))
        else $error("first byte not kept");

endmodule
